[rtl/cfpu_pkg.sv]
package cfpu_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_SEQ     = 7'b0000010,
    PH_MSGID   = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CRC_LO  = 7'b0100000,
    PH_CRC_HI  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    CRC_HOLD  = 2'd0,
    CRC_CLEAR = 2'd1,
    CRC_FEED  = 2'd2,
    CRC_SEED  = 2'd3
  } crc_op_t;

  typedef struct packed {
    crc_op_t           op;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              frame_end;
    logic              frame_good;
    logic [BYTE_W-1:0] frame_seq;
    logic [BYTE_W-1:0] frame_msg_id;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

endpackage

[rtl/cfpu_crc.sv]
module cfpu_crc (
  input  logic                      clk,
  input  logic                      rst,
  input  cfpu_pkg::crc_ctrl_t       ctrl,
  output logic [cfpu_pkg::CRC_W-1:0] crc
);
  import cfpu_pkg::*;

  // Modbus CRC-16 byte update, reflected, eight shift steps
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [CRC_W-1:0] crc_next;

  always_comb begin
    case (ctrl.op)
      CRC_CLEAR: crc_next = CRC_INIT;
      CRC_FEED:  crc_next = crc_feed(crc, ctrl.data);
      CRC_SEED:  crc_next = crc_feed(CRC_INIT, ctrl.data);
      default:   crc_next = crc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

[rtl/cfpu_parser.sv]
module cfpu_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cfpu_pkg::BYTE_W-1:0] cfg_wdata,
  input  logic                        in_fire,
  input  logic [cfpu_pkg::BYTE_W-1:0] in_byte,
  input  logic [cfpu_pkg::CRC_W-1:0]  crc,
  output cfpu_pkg::crc_ctrl_t         crc_ctrl,
  output cfpu_pkg::result_t           result
);
  import cfpu_pkg::*;

  logic [BYTE_W-1:0] header_byte;
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] payload_count, payload_count_next;
  logic [BYTE_W-1:0] held_seq, held_seq_next;
  logic [BYTE_W-1:0] held_msg_id, held_msg_id_next;
  logic [BYTE_W-1:0] held_length, held_length_next;
  logic [BYTE_W-1:0] crc_low_byte, crc_low_byte_next;
  logic [BYTE_W-1:0] count_inc;
  crc_op_t           op;

  assign count_inc = payload_count + 1'b1;

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    held_seq_next      = held_seq;
    held_msg_id_next   = held_msg_id;
    held_length_next   = held_length;
    crc_low_byte_next  = crc_low_byte;
    op                 = CRC_HOLD;
    result             = '0;

    case (phase)
      PH_SEQ: begin
        held_seq_next = in_byte;
        op            = CRC_FEED;
        phase_next    = PH_MSGID;
      end
      PH_MSGID: begin
        held_msg_id_next = in_byte;
        op               = CRC_FEED;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        held_length_next   = in_byte;
        op                 = CRC_FEED;
        payload_count_next = '0;
        // empty payload skips straight to the checksum
        phase_next         = (in_byte == '0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = in_byte;
        result.payload_index = payload_count;
        op                   = CRC_FEED;
        if (count_inc == held_length) begin
          payload_count_next = '0;
          phase_next         = PH_CRC_LO;
        end else begin
          payload_count_next = count_inc;
        end
      end
      PH_CRC_LO: begin
        crc_low_byte_next = in_byte;
        phase_next        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        result.frame_end   = 1'b1;
        result.frame_good  = ({in_byte, crc_low_byte} == crc);
        op                 = CRC_CLEAR;
        payload_count_next = '0;
        phase_next         = PH_HUNT;
      end
      default: begin
        // hunting, also any stray phase code
        payload_count_next = '0;
        if (in_byte == header_byte) begin
          op         = CRC_SEED;
          phase_next = PH_SEQ;
        end else begin
          op         = CRC_CLEAR;
          phase_next = PH_HUNT;
        end
      end
    endcase

    result.frame_seq    = held_seq_next;
    result.frame_msg_id = held_msg_id_next;
    result.frame_length = held_length_next;

    crc_ctrl.op   = in_fire ? op : CRC_HOLD;
    crc_ctrl.data = in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte   <= '0;
      phase         <= PH_HUNT;
      payload_count <= '0;
      held_seq      <= '0;
      held_msg_id   <= '0;
      held_length   <= '0;
      crc_low_byte  <= '0;
    end else begin
      if (cfg_we) begin
        header_byte <= cfg_wdata;
      end
      if (in_fire) begin
        phase         <= phase_next;
        payload_count <= payload_count_next;
        held_seq      <= held_seq_next;
        held_msg_id   <= held_msg_id_next;
        held_length   <= held_length_next;
        crc_low_byte  <= crc_low_byte_next;
      end
    end
  end

endmodule

[rtl/cfpu_out_stage.sv]
module cfpu_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  cfpu_pkg::result_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cfpu_pkg::result_t out_data
);
  import cfpu_pkg::*;

  result_t skid_data;
  logic    skid_valid;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

[rtl/crc_checked_frame_parser_unit.sv]
// Channel  Dir  tdata                                         tuser
// s_axis   in   [7:0] rx_byte                                 -
// m_axis   out  [7:0] payload_byte [15:8] payload_index       [0] payload_valid
//               [23:16] frame_seq [31:24] frame_msg_id        [1] frame_good
//               [39:32] frame_length; tlast = frame_end
// cfg      in   cfg_we / cfg_wdata write header_byte
//
// One byte per cycle while s_tready is high; each byte yields one result transaction.
// Each result is registered in the output stage, behind the parser phase logic
// and the one-byte CRC update.
// rst is synchronous, active high: parser hunts for header, CRC = 0xFFFF,
// header_byte = 0, both output registers empty.
// One skid entry beside the result register keeps s_tready high when the
// output first stalls; s_tready drops only once the skid entry is occupied.
module crc_checked_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_byte, payload_index, seq, msg_id, length
  output logic        m_tlast,   // frame_end
  output logic [1:0]  m_tuser    // [0] payload_valid, [1] frame_good
);
  import cfpu_pkg::*;

  logic             in_fire;
  crc_ctrl_t        crc_ctrl;
  logic [CRC_W-1:0] crc;
  result_t          res;
  result_t          out_res;

  // a byte is consumed only when the output side can take its result
  assign in_fire = s_tvalid && s_tready;

  cfpu_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc)
  );

  // phase tracking, held header fields, result forming
  cfpu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .crc       (crc),
    .crc_ctrl  (crc_ctrl),
    .result    (res)
  );

  cfpu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.frame_length, out_res.frame_msg_id, out_res.frame_seq,
                    out_res.payload_index, out_res.payload_byte};
  assign m_tlast = out_res.frame_end;
  assign m_tuser = {out_res.frame_good, out_res.payload_valid};

endmodule

[rtl/cfpu_checker.sv]
module cfpu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // every accepted byte leaves a result pending on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted byte produced no result");

  // verdict only at frame end
  a_good_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tuser[1])
    else $error("frame_good outside frame end");

  // non-payload results carry zero byte and index
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
    else $error("payload fields not cleared");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind crc_checked_frame_parser_unit cfpu_checker u_cfpu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
